>>> design/rqf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqf_pkg;

    // sizes of the window and the rank registers
    localparam int WINDOW_MAX  = 32;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;
    localparam int NUM_RANKS   = 4;
    localparam int SLOT_W      = 2;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int RANK_W      = 14;
    localparam int QCNT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 14;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN = 3'd0,
        REG_QCOUNT     = 3'd1,
        REG_RANK_A     = 3'd2,
        REG_RANK_B     = 3'd3,
        REG_RANK_C     = 3'd4,
        REG_RANK_D     = 3'd5
    } cfg_reg_t;

    // control broadcast from the sequencer to every cell of the row
    typedef struct packed {
        logic             del_phase;
        logic             ins_phase;
        logic [CNT_W-1:0] fill;
        logic [IDX_W-1:0] old_age;
        sample_t          sample;
        logic [IDX_W-1:0] rd_a;
        logic [IDX_W-1:0] rd_b;
    } cell_ctrl_t;

    // window length as used: zero reads as one, large values saturate
    function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] wl);
        logic [CNT_W-1:0] w;
        w = wl;
        if (wl == '0)
            w = CNT_W'(1);
        else if (wl > CNT_W'(WINDOW_MAX))
            w = CNT_W'(WINDOW_MAX);
        return w;
    endfunction

    // results per item as used
    function automatic logic [QCNT_W-1:0] eff_count(input logic [QCNT_W-1:0] qc);
        logic [QCNT_W-1:0] c;
        c = qc;
        if (qc == '0)
            c = QCNT_W'(1);
        else if (qc > QCNT_W'(NUM_RANKS))
            c = QCNT_W'(NUM_RANKS);
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/rqf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rqf_cell (
    input  wire logic                      clk,
    input  wire rqf_pkg::cell_ctrl_t       ctrl,
    input  wire logic [rqf_pkg::IDX_W-1:0] index,
    input  wire rqf_pkg::sample_t          left_val,
    input  wire logic [rqf_pkg::IDX_W-1:0] left_age,
    input  wire logic                      left_gt,
    input  wire rqf_pkg::sample_t          right_val,
    input  wire logic [rqf_pkg::IDX_W-1:0] right_age,
    input  wire logic                      del_in,
    input  wire rqf_pkg::sample_t          rd_a_in,
    input  wire rqf_pkg::sample_t          rd_b_in,
    output rqf_pkg::sample_t               val,
    output logic [rqf_pkg::IDX_W-1:0]      age,
    output logic                           gt,
    output logic                           del_out,
    output rqf_pkg::sample_t               rd_a_out,
    output rqf_pkg::sample_t               rd_b_out
);

    rqf_pkg::sample_t            val_reg;
    rqf_pkg::sample_t            val_next;
    logic [rqf_pkg::IDX_W-1:0]   age_reg;
    logic [rqf_pkg::IDX_W-1:0]   age_next;
    logic                        in_use;
    logic                        is_old;

    // occupancy and local compare against the incoming sample
    assign in_use  = {1'b0, index} < ctrl.fill;
    assign is_old  = in_use && (age_reg == ctrl.old_age);
    assign gt      = !in_use || (val_reg > ctrl.sample);
    assign del_out = del_in || is_old;

    // read taps, or-ed along the row
    assign rd_a_out = rd_a_in | ((index == ctrl.rd_a) ? val_reg : '0);
    assign rd_b_out = rd_b_in | ((index == ctrl.rd_b) ? val_reg : '0);

    assign val = val_reg;
    assign age = age_reg;

    // delete closes the gap from the right, insert opens it to the left
    always_comb
    begin
        val_next = val_reg;
        age_next = age_reg;
        if (ctrl.del_phase && del_out)
        begin
            val_next = right_val;
            age_next = right_age;
        end
        else if (ctrl.ins_phase)
        begin
            if (!gt)
            begin
                age_next = age_reg + 1'b1;
            end
            else if (left_gt)
            begin
                val_next = left_val;
                age_next = left_age + 1'b1;
            end
            else
            begin
                val_next = ctrl.sample;
                age_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

endmodule

`default_nettype wire

>>> design/rqf_interp.sv
`timescale 1ns / 1ps
`default_nettype none

module rqf_interp (
    input  wire rqf_pkg::sample_t              a,
    input  wire rqf_pkg::sample_t              b,
    input  wire logic [rqf_pkg::FRAC_BITS-1:0] w,
    output rqf_pkg::sample_t                   value
);

    localparam int PW = rqf_pkg::SAMPLE_BITS + rqf_pkg::FRAC_BITS + 2;

    logic signed [rqf_pkg::FRAC_BITS+1:0] wa;
    logic signed [rqf_pkg::FRAC_BITS+1:0] wb;
    logic signed [PW-1:0]                 pa;
    logic signed [PW-1:0]                 pb;
    logic signed [PW-1:0]                 sum;

    // weights: one minus fraction for a, fraction for b
    assign wa  = $signed((rqf_pkg::FRAC_BITS+2)'(1 << rqf_pkg::FRAC_BITS)
                         - (rqf_pkg::FRAC_BITS+2)'(w));
    assign wb  = $signed({2'b00, w});
    assign pa  = PW'(a * wa);
    assign pb  = PW'(b * wb);
    assign sum = pa + pb;

    // arithmetic shift floors toward minus infinity
    assign value = sum[rqf_pkg::SAMPLE_BITS+rqf_pkg::FRAC_BITS-1:rqf_pkg::FRAC_BITS];

endmodule

`default_nettype wire

>>> design/running_quantile_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Running quantile filter: keeps the last window_len samples as a sorted row of
// cells, each cell holding one sample and its age. A new item is accepted in
// ST_IDLE; ST_DEL then drops the oldest sample when the window is already full and
// ST_INS inserts the new sample in order. Once the window is full after the insert,
// each of the quantile_count results goes through a rank clamp, a read of two
// neighbouring cells over the row's read taps and an interpolation multiply, all
// sharing one interpolation unit; the multiply waits while output back-pressure
// holds the output register. The next item is accepted only once the sequencer is
// back in ST_IDLE, after the insert or after the last result of the item.
// Results stay in the output register while the next item is already accepted.
// Writing window_len empties the window, as does an item with restart set.
module running_quantile_filter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // slave side
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // sample
    input  wire logic                          s_tuser,   // restart
    // master side
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,   // quantile_value
    output logic [1:0]                         m_tuser,   // rank_slot
    output logic                               m_tlast,   // last_of_run
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [rqf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rqf_pkg::CFG_W-1:0]     cfg_data
);

    localparam int WM = rqf_pkg::WINDOW_MAX;
    localparam int IW = rqf_pkg::IDX_W;
    localparam int CW = rqf_pkg::CNT_W;
    localparam int FB = rqf_pkg::FRAC_BITS;
    localparam int RW = rqf_pkg::RANK_W;
    localparam int SW = rqf_pkg::SLOT_W;
    localparam int QW = rqf_pkg::QCNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL,
        ST_INS,
        ST_CLAMP,
        ST_READ,
        ST_MUL
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          fill_reg, fill_next;
    rqf_pkg::sample_t       sample_reg, sample_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic [IW-1:0]          rd_a_reg, rd_a_next;
    logic [IW-1:0]          rd_b_reg, rd_b_next;
    logic [FB-1:0]          w_reg, w_next;
    rqf_pkg::sample_t       a_reg, a_next;
    rqf_pkg::sample_t       b_reg, b_next;
    logic                   out_valid_reg, out_valid_next;
    rqf_pkg::sample_t       out_data_reg, out_data_next;
    logic [SW-1:0]          out_slot_reg, out_slot_next;
    logic                   out_last_reg, out_last_next;
    logic [CW-1:0]          wlen_reg, wlen_next;
    logic [QW-1:0]          qcnt_reg, qcnt_next;
    logic [RW-1:0]          rank_reg [rqf_pkg::NUM_RANKS];
    logic [RW-1:0]          rank_next [rqf_pkg::NUM_RANKS];

    logic [CW-1:0]          n_eff;
    logic [QW-1:0]          cnt_eff;
    logic [CW-1:0]          fill_v;
    logic [CW-1:0]          fill_inc;
    logic [RW-1:0]          r_sel;
    logic [RW-1:0]          r_max;
    logic [RW-1:0]          r_c;
    logic [CW-1:0]          k;
    logic [FB-1:0]          f;
    logic                   last_slot;
    rqf_pkg::sample_t       interp_value;
    rqf_pkg::cell_ctrl_t    ctrl;

    // cell row wiring
    rqf_pkg::sample_t       cell_val [WM];
    logic [IW-1:0]          cell_age [WM];
    logic                   cell_gt  [WM];
    logic                   del_chain [WM+1];
    rqf_pkg::sample_t       rda_chain [WM+1];
    rqf_pkg::sample_t       rdb_chain [WM+1];

    assign n_eff    = rqf_pkg::eff_window(wlen_reg);
    assign cnt_eff  = rqf_pkg::eff_count(qcnt_reg);
    assign fill_inc = fill_reg + 1'b1;

    // broadcast control to the row
    assign ctrl.del_phase = (state_reg == ST_DEL);
    assign ctrl.ins_phase = (state_reg == ST_INS);
    assign ctrl.fill      = fill_reg;
    assign ctrl.old_age   = IW'(n_eff - 1'b1);
    assign ctrl.sample    = sample_reg;
    assign ctrl.rd_a      = rd_a_reg;
    assign ctrl.rd_b      = rd_b_reg;

    assign del_chain[0] = 1'b0;
    assign rda_chain[0] = '0;
    assign rdb_chain[0] = '0;

    for (genvar i = 0; i < WM; i++)
    begin : g_cell
        rqf_pkg::sample_t lv;
        logic [IW-1:0]    la;
        logic             lg;
        rqf_pkg::sample_t rv;
        logic [IW-1:0]    ra;

        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign la = '0;
            assign lg = 1'b0;
        end
        else
        begin : g_mid
            assign lv = cell_val[i-1];
            assign la = cell_age[i-1];
            assign lg = cell_gt[i-1];
        end

        if (i == WM - 1)
        begin : g_last
            assign rv = '0;
            assign ra = '0;
        end
        else
        begin : g_body
            assign rv = cell_val[i+1];
            assign ra = cell_age[i+1];
        end

        rqf_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .index     (IW'(i)),
            .left_val  (lv),
            .left_age  (la),
            .left_gt   (lg),
            .right_val (rv),
            .right_age (ra),
            .del_in    (del_chain[i]),
            .rd_a_in   (rda_chain[i]),
            .rd_b_in   (rdb_chain[i]),
            .val       (cell_val[i]),
            .age       (cell_age[i]),
            .gt        (cell_gt[i]),
            .del_out   (del_chain[i+1]),
            .rd_a_out  (rda_chain[i+1]),
            .rd_b_out  (rdb_chain[i+1])
        );
    end

    rqf_interp u_interp (
        .a     (a_reg),
        .b     (b_reg),
        .w     (w_reg),
        .value (interp_value)
    );

    // rank clamp to [1, n] and split into index and fraction
    assign r_sel = rank_reg[slot_reg];
    assign r_max = {n_eff, {FB{1'b0}}};
    always_comb
    begin
        r_c = r_sel;
        if (r_sel < RW'(1 << FB))
            r_c = RW'(1 << FB);
        else if (r_sel > r_max)
            r_c = r_max;
    end
    assign k         = r_c[RW-1:FB];
    assign f         = r_c[FB-1:0];
    assign last_slot = ({1'b0, slot_reg} == QW'(cnt_eff - 1'b1));

    // sequencer, output register and configuration
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        sample_next    = sample_reg;
        slot_next      = slot_reg;
        rd_a_next      = rd_a_reg;
        rd_b_next      = rd_b_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;
        wlen_next      = wlen_reg;
        qcnt_next      = qcnt_reg;
        fill_v         = fill_reg;
        for (int j = 0; j < rqf_pkg::NUM_RANKS; j++)
        begin
            rank_next[j] = rank_reg[j];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sample_next = s_tdata;
                    fill_v      = s_tuser ? '0 : fill_reg;
                    fill_next   = fill_v;
                    state_next  = (fill_v >= n_eff) ? ST_DEL : ST_INS;
                end
            end
            ST_DEL:
            begin
                fill_next  = fill_reg - 1'b1;
                state_next = ST_INS;
            end
            ST_INS:
            begin
                fill_next = fill_inc;
                if (fill_inc == n_eff)
                begin
                    slot_next  = '0;
                    state_next = ST_CLAMP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLAMP:
            begin
                // with no fraction, or at rank n, the upper read repeats the lower cell, so it stays inside the window
                rd_a_next  = IW'(k - 1'b1);
                rd_b_next  = ((f != '0) && (k < n_eff)) ? IW'(k) : IW'(k - 1'b1);
                w_next     = ((f != '0) && (k < n_eff)) ? f : '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                a_next     = rda_chain[WM];
                b_next     = rdb_chain[WM];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = interp_value;
                    out_slot_next  = slot_reg;
                    out_last_next  = last_slot;
                    if (last_slot)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_CLAMP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                rqf_pkg::REG_WINDOW_LEN:
                begin
                    wlen_next = cfg_data[CW-1:0];
                    fill_next = '0;
                end
                rqf_pkg::REG_QCOUNT: qcnt_next    = cfg_data[QW-1:0];
                rqf_pkg::REG_RANK_A: rank_next[0] = cfg_data[RW-1:0];
                rqf_pkg::REG_RANK_B: rank_next[1] = cfg_data[RW-1:0];
                rqf_pkg::REG_RANK_C: rank_next[2] = cfg_data[RW-1:0];
                rqf_pkg::REG_RANK_D: rank_next[3] = cfg_data[RW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            wlen_reg      <= CW'(5);
            qcnt_reg      <= QW'(1);
            rank_reg[0]   <= RW'(768);
            rank_reg[1]   <= RW'(256);
            rank_reg[2]   <= RW'(256);
            rank_reg[3]   <= RW'(256);
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            wlen_reg      <= wlen_next;
            qcnt_reg      <= qcnt_next;
            for (int j = 0; j < rqf_pkg::NUM_RANKS; j++)
            begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        rd_a_reg     <= rd_a_next;
        rd_b_reg     <= rd_b_next;
        w_reg        <= w_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        out_data_reg <= out_data_next;
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_slot_reg;
    assign m_tlast  = out_last_reg;

    // the window never holds more samples than its length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= n_eff)
        else $error("fill count exceeds window length");

    // a full window always has exactly one oldest sample to drop
    a_oldest_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEL) |-> del_chain[WM])
        else $error("no oldest sample found in the cell row");

    // the final result of an item carries the highest slot in use
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> ({1'b0, m_tuser} == QW'(cnt_eff - 1'b1)))
        else $error("last result on wrong rank slot");

    // an accepted item always starts the update
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_DEL || state_reg == ST_INS))
        else $error("accepted item did not start an update");

endmodule

`default_nettype wire
